// File: hdl/hcbp_pkg.sv
// Shared types and constants of the Huffman code bit packer.
// No dependencies; every other file of the block but hcbp_ram imports this package.
package hcbp_pkg;

  localparam int OpW     = 2;
  localparam int SymW    = 8;
  localparam int CodeW   = 32;
  localparam int LenW    = 6;
  localparam int ByteW   = 8;
  localparam int PendW   = ByteW - 1;            // bits left after the last full byte
  localparam int PcntW   = 3;                    // width of a pending bit count
  localparam int AccW    = PendW + CodeW;        // pending bits plus one full code
  localparam int CntW    = $clog2(AccW + 1);
  localparam int RamW    = CodeW + LenW;
  localparam int QDepth  = 2;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam logic [OpW-1:0] OpLoad   = 2'd0;
  localparam logic [OpW-1:0] OpEncode = 2'd1;
  localparam logic [OpW-1:0] OpFlush  = 2'd2;

  // Work item passed from the front end to the packer.
  typedef struct packed {
    logic             is_flush;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } qentry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// File: hdl/hcbp_in_if.sv
// Input channel of the bit packer: valid/ready handshake plus one command item.
// Depends on hcbp_pkg for field widths.
interface hcbp_in_if;
  import hcbp_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [SymW-1:0]  symbol;
  logic [CodeW-1:0] code_value;
  logic [LenW-1:0]  code_length;

  modport source (output valid, output op, output symbol, output code_value,
                  output code_length, input ready);
  modport sink   (input valid, input op, input symbol, input code_value,
                  input code_length, output ready);
endinterface

// File: hdl/hcbp_out_if.sv
// Output channel of the bit packer: valid/ready handshake plus one packed byte.
// Depends on hcbp_pkg for field widths.
interface hcbp_out_if;
  import hcbp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] packed_byte;
  logic             last_of_run;

  modport source (output valid, output packed_byte, output last_of_run, input ready);
  modport sink   (input valid, input packed_byte, input last_of_run, output ready);
endinterface

// File: hdl/hcbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/hcbp_front.sv
// Front end: accepts items, writes code entries, looks up codes and queues work.
// Depends on hcbp_pkg, hcbp_in_if and hcbp_ram.
module hcbp_front #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  hcbp_in_if.sink          in_i,
  output logic             push_o,
  output hcbp_pkg::qentry_t entry_o,
  input  hcbp_pkg::qstat_t qstat_i
);
  import hcbp_pkg::*;

  localparam int AddrW    = $clog2(SYMBOL_COUNT);
  localparam int LenLimit = (MAX_CODE_LEN > CodeW) ? CodeW : MAX_CODE_LEN;
  localparam logic [LenW-1:0] LenMax = LenW'(LenLimit);

  logic             accept;
  logic             sym_ok;
  logic [LenW-1:0]  ld_len;
  logic [CodeW-1:0] ld_mask;
  logic             ram_we;
  logic             ram_re;
  logic [RamW-1:0]  ram_wdata;
  logic [RamW-1:0]  ram_rdata;
  logic [LenW-1:0]  rd_len;
  logic [LenW-1:0]  s1_len;
  logic [CodeW-1:0] s1_mask;
  logic             drop;
  logic             s1_go;

  logic s1_valid_q, s1_valid_d;
  logic s1_flush_q, s1_flush_d;
  logic s1_ok_q, s1_ok_d;

  assign accept = in_i.valid && in_i.ready;
  assign sym_ok = {1'b0, in_i.symbol} < (SymW + 1)'(SYMBOL_COUNT);

  // Saturate and trim the entry before it is stored.
  assign ld_len    = (in_i.code_length > LenMax) ? LenMax : in_i.code_length;
  assign ld_mask   = CodeW'(((CodeW + 1)'(1) << ld_len) - (CodeW + 1)'(1));
  assign ram_wdata = {ld_len, in_i.code_value & ld_mask};
  assign ram_we    = accept && (in_i.op == OpLoad) && sym_ok;
  assign ram_re    = accept && (in_i.op == OpEncode);

  hcbp_ram #(
    .WIDTH (RamW),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.symbol[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_i.symbol[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Lookup stage: RAM data is valid while s1 holds an encode item.
  assign rd_len  = ram_rdata[CodeW +: LenW];
  assign s1_len  = s1_flush_q ? '0 :
                   (!s1_ok_q ? '0 : ((rd_len > LenMax) ? LenMax : rd_len));
  assign s1_mask = CodeW'(((CodeW + 1)'(1) << s1_len) - (CodeW + 1)'(1));
  assign drop    = !s1_flush_q && (s1_len == '0);
  assign s1_go   = s1_valid_q && (drop || !qstat_i.full);

  assign in_i.ready = !s1_valid_q || s1_go;
  assign push_o     = s1_valid_q && !drop && !qstat_i.full;

  assign entry_o.is_flush = s1_flush_q;
  assign entry_o.code     = ram_rdata[CodeW-1:0] & s1_mask;
  assign entry_o.len      = s1_len;

  always_comb begin
    s1_valid_d = s1_valid_q && !s1_go;
    s1_flush_d = s1_flush_q;
    s1_ok_d    = s1_ok_q;
    if (accept) begin
      unique case (in_i.op)
        OpEncode: begin
          s1_valid_d = 1'b1;
          s1_flush_d = 1'b0;
          s1_ok_d    = sym_ok;
        end
        OpFlush: begin
          s1_valid_d = 1'b1;
          s1_flush_d = 1'b1;
          s1_ok_d    = 1'b0;
        end
        default: begin
          s1_valid_d = 1'b0;   // load or unused code: nothing left to do
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
      s1_ok_q    <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_flush_q <= s1_flush_d;
      s1_ok_q    <= s1_ok_d;
    end
  end

endmodule

// File: hdl/hcbp_queue.sv
// Two-entry work queue between the front end and the packer.
// Depends on hcbp_pkg.
module hcbp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hcbp_pkg::qentry_t entry_i,
  input  logic              pop_i,
  output hcbp_pkg::qentry_t entry_o,
  output hcbp_pkg::qstat_t  qstat_o
);
  import hcbp_pkg::*;

  qentry_t entries_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign qstat_o.full  = (cnt_q == QCntW'(QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign entry_o       = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: hdl/hcbp_back.sv
// Packer: appends queued codes to the bit accumulator and emits bytes one a cycle while the output takes them.
// Depends on hcbp_pkg and hcbp_out_if.
module hcbp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcbp_pkg::qentry_t entry_i,
  input  hcbp_pkg::qstat_t  qstat_i,
  output logic              pop_o,
  hcbp_out_if.source        out_o
);
  import hcbp_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic state_q, state_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic            last_q, last_d;

  logic             out_free;
  logic [PendW-1:0] pend;
  logic [AccW-1:0]  acc_shift;
  logic [ByteW-1:0] flush_byte;
  logic [CntW-1:0]  enc_cnt;
  logic [CntW-1:0]  rem_cnt;

  assign out_free  = !out_valid_q || out_o.ready;
  // In idle fewer than a byte of bits is left; only those low bits are live.
  assign pend      = acc_q[PendW-1:0] &
                     PendW'(((PendW + 1)'(1) << cnt_q[PcntW-1:0]) - (PendW + 1)'(1));
  assign acc_shift = acc_q >> (cnt_q - CntW'(ByteW));
  assign flush_byte = {1'b0, pend} << ((PcntW + 1)'(ByteW) - {1'b0, cnt_q[PcntW-1:0]});
  assign enc_cnt   = CntW'(cnt_q[PcntW-1:0]) + CntW'(entry_i.len);
  assign rem_cnt   = cnt_q - CntW'(ByteW);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    byte_d      = byte_q;
    last_d      = last_q;
    unique case (state_q)
      StIdle: begin
        if (!qstat_i.empty) begin
          if (!entry_i.is_flush) begin
            pop_o   = 1'b1;
            acc_d   = (AccW'(pend) << entry_i.len) | AccW'(entry_i.code);
            cnt_d   = enc_cnt;
            state_d = (enc_cnt >= CntW'(ByteW)) ? StEmit : StIdle;
          end else if (cnt_q[PcntW-1:0] == '0) begin
            pop_o = 1'b1;     // empty flush
          end else if (out_free) begin
            pop_o       = 1'b1;
            out_valid_d = 1'b1;
            byte_d      = flush_byte;
            last_d      = 1'b1;
            acc_d       = '0;
            cnt_d       = '0;
          end
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          byte_d      = acc_shift[ByteW-1:0];
          last_d      = (rem_cnt < CntW'(ByteW));
          cnt_d       = rem_cnt;
          state_d     = (rem_cnt < CntW'(ByteW)) ? StIdle : StEmit;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.packed_byte = byte_q;
  assign out_o.last_of_run = last_q;

endmodule

// File: hdl/huffman_code_bit_packer.sv
// Huffman code bit packer top level: front end, work queue and packer.
// Depends on hcbp_pkg, hcbp_in_if, hcbp_out_if, hcbp_front, hcbp_queue, hcbp_back.
//
//   channel | dir | fields                                   | handshake
//   --------+-----+------------------------------------------+-------------
//   in_i    | in  | op, symbol, code_value, code_length      | valid/ready
//   out_o   | out | packed_byte, last_of_run                 | valid/ready
//
// The front end takes one item a cycle while the queue is not full; an
// encode reads the code RAM into the lookup stage, then enters the queue.
// The packer adds a code to the accumulator, then emits each full byte; a
// flush emits held bits as a last byte. Reset clears the accumulator and the
// queue, not the code RAM. A stalled output backs up the queue, then input.
module huffman_code_bit_packer #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  hcbp_in_if.sink   in_i,
  hcbp_out_if.source out_o
);
  import hcbp_pkg::*;

  logic    q_push;
  logic    q_pop;
  qentry_t q_wr_entry;
  qentry_t q_rd_entry;
  qstat_t  q_st;

  hcbp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .push_o  (q_push),
    .entry_o (q_wr_entry),
    .qstat_i (q_st)
  );

  hcbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .qstat_o (q_st)
  );

  hcbp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (q_rd_entry),
    .qstat_i (q_st),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_st.full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_st.empty)
    else $error("queue pop while empty");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop && !q_st.empty) |=> q_st.full)
    else $error("queue count lost an item");
`endif

endmodule

// File: tb/tb.sv
// Testbench of the Huffman code bit packer: loads codes, encodes and flushes, directed and at random.
// Predicts the packed byte stream in a small class and checks it item by item.
// Depends on hcbp_pkg, hcbp_in_if, hcbp_out_if and huffman_code_bit_packer.
module tb;
  import hcbp_pkg::*;

  localparam int SymCount   = 256;
  localparam int MaxCodeLen = 32;
  localparam int LenCap     = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int CycleLimit = 200000;
  localparam int TailCycles = 32;
  localparam int PhaseItems = 98;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } packed_out_t;

  // Code table plus bit accumulator; holds the bytes still owed by the block.
  class bit_packer_model;
    logic [CodeW-1:0] code_mem [SymCount];
    logic [LenW-1:0]  len_mem  [SymCount];
    logic [PendW-1:0] held_bits;
    logic [PcntW-1:0] held_cnt;
    packed_out_t      owed_bytes [$];
    int               errors;

    function new();
      held_bits = '0;
      held_cnt  = '0;
      errors    = 0;
    endfunction

    function void take_command(logic [OpW-1:0] op, logic [SymW-1:0] sym,
                               logic [CodeW-1:0] value, logic [LenW-1:0] len);
      logic [63:0]      acc;
      logic [63:0]      mask;
      logic [LenW-1:0]  clen;
      logic [ByteW-1:0] wide;
      packed_out_t      item;
      int               total;
      case (op)
        OpLoad: begin
          clen = (len > LenCap) ? LenCap[LenW-1:0] : len;
          mask = (64'd1 << clen) - 64'd1;
          code_mem[sym] = value & mask[CodeW-1:0];
          len_mem[sym]  = clen;
        end
        OpEncode: begin
          clen = len_mem[sym];
          if (clen > LenCap) clen = LenCap[LenW-1:0];
          if (clen != 0) begin
            mask  = (64'd1 << clen) - 64'd1;
            acc   = ({57'd0, held_bits} << clen) | ({32'd0, code_mem[sym]} & mask);
            total = held_cnt + clen;
            while (total >= ByteW) begin
              total     = total - ByteW;
              item.data = acc[total +: ByteW];
              item.last = (total < ByteW);
              owed_bytes.insert(owed_bytes.size(), item);
            end
            mask      = acc & ((64'd1 << total) - 64'd1);
            held_bits = mask[PendW-1:0];
            held_cnt  = total[PcntW-1:0];
          end
        end
        OpFlush: begin
          if (held_cnt != 0) begin
            wide      = {1'b0, held_bits};
            item.data = wide << (ByteW - held_cnt);
            item.last = 1'b1;
            owed_bytes.insert(owed_bytes.size(), item);
            held_bits = '0;
            held_cnt  = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void match_byte(logic [ByteW-1:0] data, logic last);
      packed_out_t want;
      if (owed_bytes.size() == 0) begin
        $display("%0t: unexpected byte %h last %b", $time, data, last);
        errors++;
      end else begin
        want = owed_bytes.pop_front();
        if (want.data !== data) begin
          $display("%0t: packed_byte expected %h actual %h", $time, want.data, data);
          errors++;
        end
        if (want.last !== last) begin
          $display("%0t: last_of_run expected %b actual %b", $time, want.last, last);
          errors++;
        end
      end
    endfunction

    function int owed();
      return owed_bytes.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   cycle_cnt;
  bit   loaded_map [SymCount];
  int   loaded_syms [$];
  bit_packer_model book;

  hcbp_in_if  in_if ();
  hcbp_out_if out_if ();

  huffman_code_bit_packer #(
    .SYMBOL_COUNT(SymCount),
    .MAX_CODE_LEN(MaxCodeLen)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Byte sink: check what was taken at this edge, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      book.match_byte(out_if.packed_byte, out_if.last_of_run);
    end
    out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic issue_command(input logic [OpW-1:0] op, input logic [SymW-1:0] sym,
                               input logic [CodeW-1:0] value,
                               input logic [LenW-1:0] len);
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.symbol      <= sym;
    in_if.code_value  <= value;
    in_if.code_length <= len;
    do @(posedge clk_i); while (!in_if.ready);
    book.take_command(op, sym, value, len);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic load_code(input logic [SymW-1:0] sym, input logic [CodeW-1:0] value,
                           input logic [LenW-1:0] len);
    issue_command(OpLoad, sym, value, len);
    if (!loaded_map[sym]) begin
      loaded_map[sym] = 1'b1;
      loaded_syms.insert(loaded_syms.size(), sym);
    end
  endtask

  task automatic encode(input logic [SymW-1:0] sym);
    // code_value and code_length are don't-care on encode; keep them toggling
    issue_command(OpEncode, sym, $urandom, LenW'($urandom_range(63)));
  endtask

  // Hold the sender until every owed byte has drained.
  task automatic drain_output();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (book.owed() != 0);
  endtask

  task automatic run_phase(input int items, input bit with_pause);
    int              sent;
    int              pick;
    int              lr;
    logic [LenW-1:0] len;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (with_pause && sent == items / 2) begin
        drain_output();
      end
      if (pick < 18) begin
        lr = $urandom_range(99);
        if (lr < 8)       len = '0;
        else if (lr < 70) len = LenW'($urandom_range(10, 1));
        else if (lr < 90) len = LenW'($urandom_range(32, 11));
        else              len = LenW'($urandom_range(63, 33));
        load_code(SymW'($urandom_range(255)), $urandom, len);
        sent++;
      end else if (pick < 88) begin
        encode(SymW'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]));
        sent++;
      end else if (pick < 96) begin
        issue_command(OpFlush, SymW'($urandom_range(255)), $urandom,
                      LenW'($urandom_range(63)));
        sent++;
      end else begin
        // unused opcode, ignored by the block
        issue_command(OpUnused, SymW'($urandom_range(255)), $urandom,
                      LenW'($urandom_range(63)));
      end
    end
  endtask

  initial begin
    book         = new();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rst_ni       = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.op          <= OpLoad;
    in_if.symbol      <= '0;
    in_if.code_value  <= '0;
    in_if.code_length <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty flush, zero-length, full-width, overlong and stray-bit codes.
    issue_command(OpFlush, 8'd0, 32'd0, 6'd0);
    load_code(8'd0, 32'h0000_ffff, 6'd0);
    load_code(8'd255, 32'hffff_ffff, 6'd32);
    load_code(8'd1, 32'h0000_0005, 6'd3);
    load_code(8'd2, 32'hffff_ffff, 6'd63);
    load_code(8'd3, 32'habcd_ef12, 6'd7);
    load_code(8'd4, 32'h0000_0000, 6'd1);
    load_code(8'd128, 32'h0000_0000, 6'd32);
    encode(8'd0);
    encode(8'd1);
    issue_command(OpFlush, 8'hff, 32'hffff_ffff, 6'h3f);
    encode(8'd255);
    encode(8'd1);
    encode(8'd255);
    encode(8'd2);
    encode(8'd3);
    encode(8'd3);
    issue_command(OpUnused, 8'hff, 32'hffff_ffff, 6'h3f);
    issue_command(OpFlush, 8'd0, 32'd0, 6'd0);
    // seven bits held, then a full 32-bit code on top
    encode(8'd3);
    encode(8'd255);
    encode(8'd128);
    encode(8'd4);
    issue_command(OpFlush, 8'd0, 32'd0, 6'd0);

    run_phase(PhaseItems, 1'b0);
    tx_idle_pct = 64;
    run_phase(PhaseItems, 1'b1);
    tx_idle_pct  = 0;
    rx_stall_pct = 64;
    run_phase(PhaseItems, 1'b0);
    tx_idle_pct  = 22;
    rx_stall_pct = 22;
    run_phase(PhaseItems, 1'b0);

    drain_output();
    repeat (TailCycles) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/hcbp_pkg.sv
hdl/hcbp_in_if.sv
hdl/hcbp_out_if.sv
hdl/hcbp_ram.sv
hdl/hcbp_front.sv
hdl/hcbp_queue.sv
hdl/hcbp_back.sv
hdl/huffman_code_bit_packer.sv
tb/tb.sv
